@@ sv/body_to_earth_tilt_rotation_unit_macros.svh @@
// assertion macros shared by the tilt rotation rtl
`ifndef BODY_TO_EARTH_TILT_ROTATION_UNIT_MACROS_SVH
`define BODY_TO_EARTH_TILT_ROTATION_UNIT_MACROS_SVH

// same-cycle implication, idle during reset
`define BETR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check in the cycle after reset is applied
`define BETR_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error(msg);

`endif

@@ sv/betr_pkg.sv @@
// constants and tables for the tilt rotation pipeline
package betr_pkg;

    // angle field and turn reduction
    localparam int ANGLE_W    = 16;
    localparam int TURN_HUND  = 36000;
    localparam int BASE_MUL   = 119304;     // floor(2^32 / 36000)
    localparam int FRAC_MUL   = 1456;       // (2^32 mod 36000) / 16
    localparam int FRAC_ADD   = 1125;       // 18000 / 16
    localparam int MP_W       = 26;
    localparam int RECIP_W    = 26;
    localparam logic [RECIP_W-1:0] RECIP_2250 = 26'd61083980;  // ceil(2^37 / 2250)
    localparam int RECIP_SH   = 37;
    localparam int QUOT_W     = 15;

    // cordic datapath
    localparam int CW           = 33;
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [CW-1:0] ATAN_TURN [ATAN_ENTRIES] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
        33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
        33'sd652,       33'sd326,       33'sd163,       33'sd81
    };

    // trig values in q1.15 with one guard bit, and their pair products
    localparam int TRIG_W = 17;
    localparam int PAIR_W = 2 * TRIG_W;

endpackage

@@ sv/betr_if.sv @@
// valid/ready channels for body samples in and earth vectors out
interface betr_in_if import betr_pkg::*; #(parameter int SAMPLE_WIDTH = 16) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] body_x;
    logic signed [SAMPLE_WIDTH-1:0] body_y;
    logic signed [SAMPLE_WIDTH-1:0] body_z;
    logic signed [ANGLE_W-1:0]      pitch_angle;
    logic signed [ANGLE_W-1:0]      roll_angle;

    modport source (output valid, body_x, body_y, body_z, pitch_angle, roll_angle,
                    input ready);
    modport sink (input valid, body_x, body_y, body_z, pitch_angle, roll_angle,
                  output ready);
    modport monitor (input valid, ready, body_x, body_y, body_z, pitch_angle, roll_angle);
endinterface

interface betr_out_if #(parameter int SAMPLE_WIDTH = 16) ();
    logic                         valid;
    logic                         ready;
    logic signed [SAMPLE_WIDTH:0] earth_x;
    logic signed [SAMPLE_WIDTH:0] earth_y;
    logic signed [SAMPLE_WIDTH:0] earth_z;

    modport source (output valid, earth_x, earth_y, earth_z, input ready);
    modport sink (input valid, earth_x, earth_y, earth_z, output ready);
    modport monitor (input valid, ready, earth_x, earth_y, earth_z);
endinterface

@@ sv/body_to_earth_tilt_rotation_unit.sv @@
// pitch-roll rotation of a body-frame vector into the earth frame
//
// Channel i_in carries one transaction per sample: body_x/y/z and pitch and
// roll in hundredths of a degree. Channel o_out returns one transaction per
// input with earth_x/y/z, rounded and saturated to SAMPLE_WIDTH+1 bits.
// Both use valid/ready; a transaction moves when both are high.
// Stages run in order: input register, angle reduction, division, phase,
// the cordic stage chain, trig rounding, pair products, matrix terms, sums
// and output. Throughput is one transaction per cycle while o_out.ready is
// high: each stage has its own valid bit and loads whenever it is empty or
// the stage after it moves, so empty slots are filled while the output
// waits and i_in.ready drops only once every stage holds an item. A stalled
// output holds its value; nothing is lost or repeated. Reset (i_rst_n low,
// synchronous) clears the valid bits only; the data registers are not reset.
`include "body_to_earth_tilt_rotation_unit_macros.svh"

module body_to_earth_tilt_rotation_unit import betr_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int TRIG_STAGES  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    betr_in_if.sink    i_in,
    betr_out_if.source o_out
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int ACC_W  = SW + 32;
    localparam int S_RED  = 1;
    localparam int S_DIV  = 2;
    localparam int S_PH   = 3;
    localparam int S_CO   = 4;
    localparam int S_CS   = S_CO + TRIG_STAGES;
    localparam int S_PR   = S_CS + 1;
    localparam int S_TM   = S_CS + 2;
    localparam int S_SU   = S_CS + 3;
    localparam int S_OUT  = S_CS + 4;
    localparam int NS     = S_OUT + 1;
    localparam logic signed [CW-1:0]    Z_BOUND = 2 * ATAN_TURN[TRIG_STAGES-1];
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< 29);

    // stage valid bits and per-stage load enables
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    assign en[NS-1] = !r_v[NS-1] || o_out.ready;
    for (genvar g = 0; g < NS - 1; g++) begin : g_en
        assign en[g] = !r_v[g] || en[g+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign i_in.ready  = en[0];
    assign o_out.valid = r_v[NS-1];

    // body samples travel alongside until the product stage
    logic signed [SW-1:0] r_bx [S_PR+1];
    logic signed [SW-1:0] r_by [S_PR+1];
    logic signed [SW-1:0] r_bz [S_PR+1];
    logic signed [ANGLE_W-1:0] r_ang [2];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_bx[0]  <= i_in.body_x;
            r_by[0]  <= i_in.body_y;
            r_bz[0]  <= i_in.body_z;
            r_ang[0] <= i_in.pitch_angle;
            r_ang[1] <= i_in.roll_angle;
        end
    end

    for (genvar g = 1; g <= S_PR; g++) begin : g_body
        always_ff @(posedge i_clk) begin
            if (en[g]) begin
                r_bx[g] <= r_bx[g-1];
                r_by[g] <= r_by[g-1];
                r_bz[g] <= r_bz[g-1];
            end
        end
    end

    // per-angle reduction, cordic and quadrant fold (0 pitch, 1 roll)
    logic signed [CW-1:0]     r_x [2][TRIG_STAGES+1];
    logic signed [CW-1:0]     r_y [2][TRIG_STAGES+1];
    logic signed [CW-1:0]     r_z [2][TRIG_STAGES+1];
    logic [1:0]               r_q [2][TRIG_STAGES+1];
    logic signed [TRIG_W-1:0] r_c [2];
    logic signed [TRIG_W-1:0] r_s [2];

    for (genvar k = 0; k < 2; k++) begin : g_ang
        logic [ANGLE_W:0]          w_wrap;
        logic [ANGLE_W-1:0]        w_r;
        logic [MP_W-1:0]           r_mp;
        logic [31:0]               r_base_a;
        logic [31:0]               r_base_b;
        logic [MP_W+RECIP_W-1:0]   w_prod;
        logic [QUOT_W-1:0]         r_quot;
        logic [31:0]               w_phase;
        logic [31:0]               w_qoff;
        logic [1:0]                w_q;
        logic [31:0]               w_res;
        logic signed [CW-1:0]      w_xr;
        logic signed [CW-1:0]      w_yr;
        logic signed [TRIG_W-1:0]  w_xc;
        logic signed [TRIG_W-1:0]  w_ys;

        // fold negative angles into one turn
        assign w_wrap = {r_ang[k][ANGLE_W-1], r_ang[k]} + (ANGLE_W+1)'(TURN_HUND);
        assign w_r    = r_ang[k][ANGLE_W-1] ? w_wrap[ANGLE_W-1:0] : r_ang[k];

        always_ff @(posedge i_clk) begin
            if (en[S_RED]) begin
                r_mp     <= MP_W'(w_r * FRAC_MUL + FRAC_ADD);
                r_base_a <= 32'(w_r * BASE_MUL);
            end
        end

        // quotient by 2250 through the reciprocal
        assign w_prod = (MP_W+RECIP_W)'(r_mp) * (MP_W+RECIP_W)'(RECIP_2250);

        always_ff @(posedge i_clk) begin
            if (en[S_DIV]) begin
                r_quot   <= w_prod[RECIP_SH +: QUOT_W];
                r_base_b <= r_base_a;
            end
        end

        // turn phase, quadrant and residual angle
        assign w_phase = r_base_b + 32'(r_quot);
        assign w_qoff  = w_phase + 32'h2000_0000;
        assign w_q     = w_qoff[31:30];
        assign w_res   = w_phase - {w_q, 30'b0};

        always_ff @(posedge i_clk) begin
            if (en[S_PH]) begin
                r_x[k][0] <= GAIN_Q30;
                r_y[k][0] <= '0;
                r_z[k][0] <= CW'(signed'(w_res));
                r_q[k][0] <= w_q;
            end
        end

        // one cordic micro-rotation per stage
        for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cordic
            always_ff @(posedge i_clk) begin
                if (en[S_CO+i]) begin
                    r_q[k][i+1] <= r_q[k][i];
                    if (!r_z[k][i][CW-1]) begin
                        r_x[k][i+1] <= r_x[k][i] - (r_y[k][i] >>> i);
                        r_y[k][i+1] <= r_y[k][i] + (r_x[k][i] >>> i);
                        r_z[k][i+1] <= r_z[k][i] - ATAN_TURN[i];
                    end else begin
                        r_x[k][i+1] <= r_x[k][i] + (r_y[k][i] >>> i);
                        r_y[k][i+1] <= r_y[k][i] - (r_x[k][i] >>> i);
                        r_z[k][i+1] <= r_z[k][i] + ATAN_TURN[i];
                    end
                end
            end
        end

        // round to q1.15 and fold by quadrant
        assign w_xr = r_x[k][TRIG_STAGES] + CW'(16384);
        assign w_yr = r_y[k][TRIG_STAGES] + CW'(16384);
        assign w_xc = w_xr[15 +: TRIG_W];
        assign w_ys = w_yr[15 +: TRIG_W];

        always_ff @(posedge i_clk) begin
            if (en[S_CS]) begin
                case (r_q[k][TRIG_STAGES])
                    2'd0: begin
                        r_c[k] <= w_xc;
                        r_s[k] <= w_ys;
                    end
                    2'd1: begin
                        r_c[k] <= -w_ys;
                        r_s[k] <= w_xc;
                    end
                    2'd2: begin
                        r_c[k] <= -w_xc;
                        r_s[k] <= -w_ys;
                    end
                    default: begin
                        r_c[k] <= w_ys;
                        r_s[k] <= -w_xc;
                    end
                endcase
            end
        end
    end

    // pair products of the rotation matrix
    logic signed [TRIG_W-1:0] r_ct, r_st, r_cp, r_sp;
    logic signed [PAIR_W-1:0] r_pst, r_cst, r_sct, r_cct;

    always_ff @(posedge i_clk) begin
        if (en[S_PR]) begin
            r_ct  <= r_c[0];
            r_st  <= r_s[0];
            r_cp  <= r_c[1];
            r_sp  <= r_s[1];
            r_pst <= PAIR_W'(r_s[1]) * PAIR_W'(r_s[0]);
            r_cst <= PAIR_W'(r_c[1]) * PAIR_W'(r_s[0]);
            r_sct <= PAIR_W'(r_s[1]) * PAIR_W'(r_c[0]);
            r_cct <= PAIR_W'(r_c[1]) * PAIR_W'(r_c[0]);
        end
    end

    // matrix terms at scale 2^30
    logic signed [ACC_W-1:0] r_tx0, r_tx1, r_tx2, r_ty0, r_ty1, r_tz0, r_tz1, r_tz2;

    always_ff @(posedge i_clk) begin
        if (en[S_TM]) begin
            r_tx0 <= (ACC_W'(r_ct) * ACC_W'(r_bx[S_PR])) <<< 15;
            r_tx1 <= ACC_W'(r_pst) * ACC_W'(r_by[S_PR]);
            r_tx2 <= ACC_W'(r_cst) * ACC_W'(r_bz[S_PR]);
            r_ty0 <= (ACC_W'(r_cp) * ACC_W'(r_by[S_PR])) <<< 15;
            r_ty1 <= (ACC_W'(r_sp) * ACC_W'(r_bz[S_PR])) <<< 15;
            r_tz0 <= (ACC_W'(r_st) * ACC_W'(r_bx[S_PR])) <<< 15;
            r_tz1 <= ACC_W'(r_sct) * ACC_W'(r_by[S_PR]);
            r_tz2 <= ACC_W'(r_cct) * ACC_W'(r_bz[S_PR]);
        end
    end

    // sums with the rounding half folded in
    logic signed [ACC_W-1:0] r_sx, r_sy, r_sz;

    always_ff @(posedge i_clk) begin
        if (en[S_SU]) begin
            r_sx <= r_tx0 + r_tx1 + r_tx2 + ROUND_HALF;
            r_sy <= r_ty0 - r_ty1 + ROUND_HALF;
            r_sz <= r_tz1 + r_tz2 - r_tz0 + ROUND_HALF;
        end
    end

    // drop the fraction and saturate
    function automatic logic signed [SW:0] sat_out(input logic signed [ACC_W-1:0] acc);
        logic signed [SW+1:0] v;
        v = acc[ACC_W-1:30];
        if (v[SW+1] != v[SW]) begin
            return v[SW+1] ? {1'b1, {SW{1'b0}}} : {1'b0, {SW{1'b1}}};
        end
        return v[SW:0];
    endfunction

    logic signed [SW:0] r_ex, r_ey, r_ez;

    always_ff @(posedge i_clk) begin
        if (en[S_OUT]) begin
            r_ex <= sat_out(r_sx);
            r_ey <= sat_out(r_sy);
            r_ez <= sat_out(r_sz);
        end
    end

    assign o_out.earth_x = r_ex;
    assign o_out.earth_y = r_ey;
    assign o_out.earth_z = r_ez;

    // checks
    `BETR_ASSERT_RST(a_rst_empty, !o_out.valid, "output valid right after reset")
    `BETR_ASSERT_IMPL(a_cordic_conv, r_v[S_CS-1], (r_z[0][TRIG_STAGES] <= Z_BOUND) && (r_z[0][TRIG_STAGES] >= -Z_BOUND) && (r_z[1][TRIG_STAGES] <= Z_BOUND) && (r_z[1][TRIG_STAGES] >= -Z_BOUND), "cordic residual did not converge")
    `BETR_ASSERT_IMPL(a_trig_range, r_v[S_CS], (r_c[0] <= 17'sd32768) && (r_c[0] >= -17'sd32768) && (r_s[1] <= 17'sd32768) && (r_s[1] >= -17'sd32768), "trig value out of q1.15 range")

endmodule

@@ verif/body_to_earth_tilt_rotation_unit_checker.sv @@
// checker: predicts each earth-frame vector and compares the output transactions
module body_to_earth_tilt_rotation_unit_checker import betr_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int TRIG_STAGES  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    betr_in_if.monitor  i_in_mon,
    betr_out_if.monitor i_out_mon,
    output int          o_errors,
    output int          o_pending
);

    typedef struct {
        logic signed [SAMPLE_WIDTH:0] ex;
        logic signed [SAMPLE_WIDTH:0] ey;
        logic signed [SAMPLE_WIDTH:0] ez;
    } t_earth_vec;

    t_earth_vec earth_q[$];
    int         n_err;

    assign o_errors  = n_err;
    assign o_pending = earth_q.size();

    // cosine and sine of an angle in hundredths of a degree, q15
    task automatic angle_trig(input logic signed [15:0] ang,
                              output longint c, output longint s);
        longint r, x, y, z, xc, ys, dx, dy;
        logic [63:0] ph;
        logic [31:0] phase, res;
        logic [1:0]  quad;
        r = longint'(ang) % 36000;
        if (r < 0) r += 36000;
        ph = ((64'(r) << 32) + 64'd18000) / 64'd36000;
        phase = ph[31:0];
        quad = 2'((phase + 32'h2000_0000) >> 30);
        res = phase - (32'(quad) << 30);
        z = longint'($signed(res));
        x = longint'(GAIN_Q30);
        y = 0;
        for (int i = 0; i < TRIG_STAGES && i < ATAN_ENTRIES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
            end
        end
        xc = (x + 16384) >>> 15;
        ys = (y + 16384) >>> 15;
        case (quad)
            2'd0: begin c = xc;  s = ys;  end
            2'd1: begin c = -ys; s = xc;  end
            2'd2: begin c = -xc; s = -ys; end
            default: begin c = ys; s = -xc; end
        endcase
    endtask

    // round half up from scale 2^30 and saturate
    function automatic logic signed [SAMPLE_WIDTH:0] round_sat(input longint acc);
        longint v, hi, lo;
        v = (acc + (longint'(1) << 29)) >>> 30;
        hi = (longint'(1) << SAMPLE_WIDTH) - 1;
        lo = -(longint'(1) << SAMPLE_WIDTH);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[SAMPLE_WIDTH:0];
    endfunction

    // predict on input transaction, compare on output transaction
    always @(posedge i_clk) begin
        longint ct, st, cp, sp, bx, by, bz;
        t_earth_vec pv, got;
        if (!i_rst_n) begin
            earth_q.delete();
            n_err = 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                bx = i_in_mon.body_x;
                by = i_in_mon.body_y;
                bz = i_in_mon.body_z;
                angle_trig(i_in_mon.pitch_angle, ct, st);
                angle_trig(i_in_mon.roll_angle, cp, sp);
                pv.ex = round_sat(ct * 32768 * bx + sp * st * by + cp * st * bz);
                pv.ey = round_sat(cp * 32768 * by - sp * 32768 * bz);
                pv.ez = round_sat(-st * 32768 * bx + sp * ct * by + cp * ct * bz);
                earth_q.push_back(pv);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.ex = i_out_mon.earth_x;
                got.ey = i_out_mon.earth_y;
                got.ez = i_out_mon.earth_z;
                if (earth_q.size() == 0) begin
                    n_err++;
                    $display("%0t: unexpected transaction x=%0d y=%0d z=%0d",
                             $time, got.ex, got.ey, got.ez);
                end else begin
                    pv = earth_q.pop_front();
                    if (got.ex !== pv.ex) begin
                        n_err++;
                        $display("%0t: earth_x expected %0d actual %0d",
                                 $time, pv.ex, got.ex);
                    end
                    if (got.ey !== pv.ey) begin
                        n_err++;
                        $display("%0t: earth_y expected %0d actual %0d",
                                 $time, pv.ey, got.ey);
                    end
                    if (got.ez !== pv.ez) begin
                        n_err++;
                        $display("%0t: earth_z expected %0d actual %0d",
                                 $time, pv.ez, got.ez);
                    end
                end
            end
        end
    end

endmodule

@@ verif/body_to_earth_tilt_rotation_unit_test.sv @@
// testbench top: stimulus, idling phases and verdict for the tilt rotation unit
module body_to_earth_tilt_rotation_unit_test;
    import betr_pkg::*;

    localparam int SW  = 16;
    localparam int LAT = 16 + 8;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending;
    int   send_idle, recv_stall, n_sent;

    betr_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
    betr_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

    body_to_earth_tilt_rotation_unit #(.SAMPLE_WIDTH(SW), .TRIG_STAGES(16)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    body_to_earth_tilt_rotation_unit_checker #(.SAMPLE_WIDTH(SW), .TRIG_STAGES(16)) u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_mon(in_ch.monitor),
        .i_out_mon(out_ch.monitor), .o_errors(errors), .o_pending(pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // drive one transaction, with random sender idling, wait for accept
    task automatic send_sample(input logic signed [15:0] bx, by, bz, pa, ra);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.body_x      <= bx;
        in_ch.body_y      <= by;
        in_ch.body_z      <= bz;
        in_ch.pitch_angle <= pa;
        in_ch.roll_angle  <= ra;
        do @(posedge i_clk); while (!in_ch.ready);
        n_sent++;
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(5))
            0: return 16'($signed($urandom_range(36000)) - 18000);
            1: return 16'($urandom);
            2: return 16'(9000 * ($signed($urandom_range(4)) - 2));
            default: return 16'($signed($urandom_range(36000)) - 18000);
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [15:0] angs [9];
        angs = '{-18000, 18000, 0, 9000, -9000, 4500, 32767, -32768, 17999};
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.body_x = '0; in_ch.body_y = '0; in_ch.body_z = '0;
        in_ch.pitch_angle = '0; in_ch.roll_angle = '0;
        send_idle = 0; recv_stall = 0; n_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme samples and angles, including wrap beyond a half turn
        for (int i = 0; i < 9; i++)
            send_sample(16'sh7fff, 16'sh8000, 16'sh7fff, angs[i], angs[8 - i]);
        for (int i = 0; i < 9; i++)
            send_sample(16'sh8000, 16'sh8000, 16'sh8000, angs[i], angs[i]);
        send_sample(0, 0, 0, 0, 0);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 4500, 4500);
        send_sample(1, -1, 1, -4500, 13500);
        in_ch.valid <= 1'b0;

        // pause until every expected result is back
        while (pending != 0) @(posedge i_clk);

        // random phases with different idling
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin send_idle = 77; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 77; end
                3: begin send_idle = 19; recv_stall = 19; end
                default: begin send_idle = 0; recv_stall = 0; end
            endcase
            for (int k = 0; k < 240; k++)
                send_sample(pick_sample(), pick_sample(), pick_sample(),
                            pick_angle(), pick_angle());
        end
        in_ch.valid <= 1'b0;

        recv_stall = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);

        $display("covered %0d samples: extreme vectors, angle wraps and quadrants,", n_sent);
        $display("under sender idling and receiver stalls");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ body_to_earth_tilt_rotation_unit.f @@
+incdir+sv
sv/betr_pkg.sv
sv/betr_if.sv
sv/body_to_earth_tilt_rotation_unit.sv
verif/body_to_earth_tilt_rotation_unit_checker.sv
verif/body_to_earth_tilt_rotation_unit_test.sv
